>>> hw/rtl/jlcg_pkg.sv
// ----------------------------------------------------------------------------
// Package for the 48-bit linear congruential generator
// Holds the request kinds, register indexes, datapath operation and operand
// codes, and the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package jlcg_pkg;

  localparam int REG_W   = 48;
  localparam int DATA_W  = 64;
  localparam int BOUND_W = 31;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MULT = 2'd0;
  localparam cfg_idx_t CFG_INC  = 2'd1;
  localparam cfg_idx_t CFG_INV  = 2'd2;

  localparam logic [REG_W-1:0] MULT_RESET = 48'd25214903917;
  localparam logic [REG_W-1:0] INC_RESET  = 48'd11;
  localparam logic [REG_W-1:0] INV_RESET  = 48'd246154705703781;

  typedef logic [3:0] kind_t;
  localparam kind_t KIND_LOAD   = 4'd0;
  localparam kind_t KIND_BITS   = 4'd1;
  localparam kind_t KIND_BOUND  = 4'd2;
  localparam kind_t KIND_LONG   = 4'd3;
  localparam kind_t KIND_FLOAT  = 4'd4;
  localparam kind_t KIND_DOUBLE = 4'd5;
  localparam kind_t KIND_FWD    = 4'd6;
  localparam kind_t KIND_BACK   = 4'd7;
  localparam kind_t KIND_CHUNK  = 4'd8;

  localparam logic [5:0] W_32 = 6'd32;
  localparam logic [5:0] W_31 = 6'd31;
  localparam logic [5:0] W_24 = 6'd24;
  localparam logic [5:0] W_26 = 6'd26;
  localparam logic [5:0] W_27 = 6'd27;

  localparam logic [9:0] RETRY_MAX = 10'd1023;

  typedef logic [4:0] op_t;
  localparam op_t OP_NONE     = 5'd0;
  localparam op_t OP_CAPTURE  = 5'd1;
  localparam op_t OP_LOAD_IN  = 5'd2;
  localparam op_t OP_MUL      = 5'd3;
  localparam op_t OP_STEP     = 5'd4;
  localparam op_t OP_V_BITS   = 5'd5;
  localparam op_t OP_V_DRAW   = 5'd6;
  localparam op_t OP_V_HI     = 5'd7;
  localparam op_t OP_V_LONG   = 5'd8;
  localparam op_t OP_V_DBL    = 5'd9;
  localparam op_t OP_V_PROD31 = 5'd10;
  localparam op_t OP_DIV      = 5'd11;
  localparam op_t OP_V_REM    = 5'd12;
  localparam op_t OP_PS_INITM = 5'd13;
  localparam op_t OP_PS_INITI = 5'd14;
  localparam op_t OP_PS_AS    = 5'd15;
  localparam op_t OP_PS_AP    = 5'd16;
  localparam op_t OP_PS_S     = 5'd17;
  localparam op_t OP_PS_P     = 5'd18;
  localparam op_t OP_SAVE_G   = 5'd19;
  localparam op_t OP_T        = 5'd20;
  localparam op_t OP_SUB      = 5'd21;
  localparam op_t OP_FWD      = 5'd22;
  localparam op_t OP_BACK     = 5'd23;
  localparam op_t OP_XS       = 5'd24;
  localparam op_t OP_CHUNK    = 5'd25;
  localparam op_t OP_ZERO     = 5'd26;
  localparam op_t OP_EMIT     = 5'd27;

  typedef logic [3:0] msel_t;
  localparam msel_t M_SEED_MULT = 4'd0;
  localparam msel_t M_BOUND_DR  = 4'd1;
  localparam msel_t M_AP_S      = 4'd2;
  localparam msel_t M_AP_P      = 4'd3;
  localparam msel_t M_P_S       = 4'd4;
  localparam msel_t M_P_P       = 4'd5;
  localparam msel_t M_AP_SEED   = 4'd6;
  localparam msel_t M_INC_G     = 4'd7;
  localparam msel_t M_T_AP      = 4'd8;
  localparam msel_t M_CX_XS     = 4'd9;
  localparam msel_t M_CZ_ZS     = 4'd10;

  typedef struct packed {
    op_t        op;
    msel_t      msel;
    logic [5:0] width;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] bits;
    logic       pow2;
    logic       n_zero;
    logic       n_lsb;
    logic       mul_done;
    logic       div_done;
    logic       reject;
    logic       out_free;
  } stat_t;

endpackage

>>> hw/rtl/java_lcg_random_generator.sv
// ----------------------------------------------------------------------------
// 48-bit linear congruential random generator
// Request in, one result out: draws, bounded ints, mantissas, jumps and
// seed loads and chunk seeds on a shared controller and datapath.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel, one item each; results leave on the m_
// channel, exactly one item per request, in order. The cfg channel writes the
// multiplier, increment and inverse multiplier and is always ready.
// Each request is taken, dispatched and then run as a sequence of steps, most of
// them 64-bit multiplies on one 32x32 multiplier.
// A bounded draw with a bound that is not a power of two retries on rejection,
// the remainder unit giving one bit a cycle. A jump runs a square-and-multiply
// loop over the significant bits of the step count, twice for a backward jump.
// One request is worked on at a time. The finished result sits in an output
// register, so a stalled receiver only holds the block at its next result.
// Reset clears the seed and step count, restores the register defaults and
// empties the output register.
// ----------------------------------------------------------------------------
module java_lcg_random_generator #(
  parameter int SEED_BITS = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // seed_in[63:0], bits[69:64], bound[100:70], steps[132:101],
  // chunk_x[164:133], chunk_z[196:165], zero fill
  input  logic [199:0] s_tdata,
  // kind[3:0]
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // value[63:0], seed_now[111:64], draw_count[175:112]
  output logic [175:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  jlcg_pkg::cmd_t  cmd;
  jlcg_pkg::stat_t st;
  logic [63:0]     out_value;
  logic [47:0]     out_seed;
  logic [63:0]     out_count;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {out_count, out_seed, out_value};

  jlcg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .st      (st),
    .cmd     (cmd)
  );

  jlcg_datapath #(
    .SEED_BITS (SEED_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_kind   (s_tuser),
    .in_seed   (s_tdata[63:0]),
    .in_bits   (s_tdata[69:64]),
    .in_bound  (s_tdata[100:70]),
    .in_steps  (s_tdata[132:101]),
    .in_cx     (s_tdata[164:133]),
    .in_cz     (s_tdata[196:165]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_seed  (out_seed),
    .out_count (out_count)
  );

endmodule

>>> hw/rtl/jlcg_mul.sv
// ----------------------------------------------------------------------------
// Iterative 64-bit multiplier
// Forms the low 64 bits of a product with one 32x32 multiplier from three
// partial products and pulses done when the product is ready.
// ----------------------------------------------------------------------------
module jlcg_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] prod,
  output logic        done
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [1:0]  ph;
  logic        busy;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] pp;

  always_comb begin
    unique case (ph)
      2'd1: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
      end
      2'd2: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
      end
      default: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
    endcase
    pp = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        ph   <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (ph == 2'd0) begin
          prod <= pp;
        end else begin
          prod <= prod + {pp[31:0], 32'd0};
        end
        if (ph == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        ph <= ph + 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/jlcg_div.sv
// ----------------------------------------------------------------------------
// Restoring remainder unit
// Computes num mod den for 31-bit operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jlcg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [jlcg_pkg::BOUND_W-1:0] num,
  input  logic [jlcg_pkg::BOUND_W-1:0] den,
  output logic [jlcg_pkg::BOUND_W-1:0] rem,
  output logic                         done
);

  logic [jlcg_pkg::BOUND_W:0]   r;
  logic [jlcg_pkg::BOUND_W-1:0] q;
  logic [4:0]                   cnt;
  logic                         busy;
  logic [jlcg_pkg::BOUND_W:0]   trial;
  logic [jlcg_pkg::BOUND_W:0]   r_next;

  always_comb begin
    trial  = {r[jlcg_pkg::BOUND_W-1:0], q[jlcg_pkg::BOUND_W-1]};
    r_next = (trial >= {1'b0, den}) ? trial - {1'b0, den} : trial;
  end

  assign rem = r[jlcg_pkg::BOUND_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r    <= '0;
        q    <= num;
        cnt  <= 5'(jlcg_pkg::BOUND_W);
        busy <= 1'b1;
      end else if (busy) begin
        r   <= r_next;
        q   <= {q[jlcg_pkg::BOUND_W-2:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/jlcg_datapath.sv
// ----------------------------------------------------------------------------
// Generator datapath
// Seed, step count, configuration registers, working registers for draws and
// jumps, the shared multiplier and remainder unit, and the output register.
// ----------------------------------------------------------------------------
module jlcg_datapath #(
  parameter int SEED_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  jlcg_pkg::cmd_t       cmd,
  output jlcg_pkg::stat_t      st,
  input  logic [3:0]           in_kind,
  input  logic [63:0]          in_seed,
  input  logic [5:0]           in_bits,
  input  logic [30:0]          in_bound,
  input  logic [31:0]          in_steps,
  input  logic [31:0]          in_cx,
  input  logic [31:0]          in_cz,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [47:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_value,
  output logic [47:0]          out_seed,
  output logic [63:0]          out_count
);

  logic [SEED_BITS-1:0] seed;
  logic [63:0]          cnt;
  logic [47:0]          mult_r;
  logic [47:0]          inc_r;
  logic [47:0]          inv_r;

  logic [3:0]  kind_r;
  logic [63:0] seed_in_r;
  logic [5:0]  bits_r;
  logic [30:0] bound_r;
  logic [31:0] steps_r;
  logic [63:0] cx_r;
  logic [63:0] cz_r;

  logic [31:0] dr;
  logic [31:0] hi_r;
  logic [63:0] val;
  logic [63:0] p_r;
  logic [63:0] s_r;
  logic [63:0] ap_r;
  logic [63:0] as_r;
  logic [63:0] g_r;
  logic [63:0] t_r;
  logic [63:0] xs_r;
  logic [31:0] n_r;

  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] prod;
  logic        mul_done;
  logic [30:0] rem;
  logic        div_done;

  logic [63:0]          seed64;
  logic [63:0]          step_sum;
  logic [SEED_BITS-1:0] seed_step;
  logic [31:0]          top32;
  logic [5:0]           wclamp;
  logic [31:0]          dr_next;
  logic [63:0]          load_word;
  logic [63:0]          fwd_sum;
  logic [63:0]          chunk_v;
  logic [63:0]          chunk_word;
  logic [31:0]          chk;

  always_comb begin
    seed64     = 64'(seed);
    step_sum   = prod + {16'd0, inc_r};
    seed_step  = step_sum[SEED_BITS-1:0];
    top32      = seed_step[SEED_BITS-1 -: 32];
    wclamp     = (cmd.width > jlcg_pkg::W_32) ? jlcg_pkg::W_32 : cmd.width;
    dr_next    = top32 >> (jlcg_pkg::W_32 - wclamp);
    load_word  = seed_in_r ^ {16'd0, mult_r};
    fwd_sum    = t_r + prod;
    chunk_v    = t_r ^ prod ^ seed_in_r;
    chunk_word = chunk_v ^ {16'd0, mult_r};
    chk        = {1'b0, dr[30:0]} - {1'b0, rem} + {1'b0, bound_r} - 32'd1;
  end

  always_comb begin
    unique case (cmd.msel)
      jlcg_pkg::M_SEED_MULT: begin
        mul_a = seed64;
        mul_b = {16'd0, mult_r};
      end
      jlcg_pkg::M_BOUND_DR: begin
        mul_a = {33'd0, bound_r};
        mul_b = {32'd0, dr};
      end
      jlcg_pkg::M_AP_S: begin
        mul_a = ap_r;
        mul_b = s_r;
      end
      jlcg_pkg::M_AP_P: begin
        mul_a = ap_r;
        mul_b = p_r;
      end
      jlcg_pkg::M_P_S: begin
        mul_a = p_r;
        mul_b = s_r;
      end
      jlcg_pkg::M_P_P: begin
        mul_a = p_r;
        mul_b = p_r;
      end
      jlcg_pkg::M_AP_SEED: begin
        mul_a = ap_r;
        mul_b = seed64;
      end
      jlcg_pkg::M_INC_G: begin
        mul_a = {16'd0, inc_r};
        mul_b = g_r;
      end
      jlcg_pkg::M_T_AP: begin
        mul_a = t_r;
        mul_b = ap_r;
      end
      jlcg_pkg::M_CX_XS: begin
        mul_a = cx_r;
        mul_b = xs_r;
      end
      jlcg_pkg::M_CZ_ZS: begin
        mul_a = cz_r;
        mul_b = val;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  jlcg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == jlcg_pkg::OP_MUL),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  jlcg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == jlcg_pkg::OP_DIV),
    .num   (dr[30:0]),
    .den   (bound_r),
    .rem   (rem),
    .done  (div_done)
  );

  always_comb begin
    st.kind     = kind_r;
    st.bits     = bits_r;
    st.pow2     = ((bound_r & (bound_r - 31'd1)) == 31'd0);
    st.n_zero   = (n_r == 32'd0);
    st.n_lsb    = n_r[0];
    st.mul_done = mul_done;
    st.div_done = div_done;
    st.reject   = chk[31];
    st.out_free = !out_valid || out_ready;
  end

  // Architectural state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      cnt       <= '0;
      mult_r    <= jlcg_pkg::MULT_RESET;
      inc_r     <= jlcg_pkg::INC_RESET;
      inv_r     <= jlcg_pkg::INV_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          jlcg_pkg::CFG_MULT: mult_r <= cfg_wdata;
          jlcg_pkg::CFG_INC:  inc_r  <= cfg_wdata;
          jlcg_pkg::CFG_INV:  inv_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.op == jlcg_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        jlcg_pkg::OP_LOAD_IN: begin
          seed <= load_word[SEED_BITS-1:0];
          cnt  <= '0;
        end
        jlcg_pkg::OP_STEP: begin
          seed <= seed_step;
          cnt  <= cnt + 64'd1;
        end
        jlcg_pkg::OP_FWD: begin
          seed <= fwd_sum[SEED_BITS-1:0];
          cnt  <= cnt + {32'd0, steps_r};
        end
        jlcg_pkg::OP_BACK: begin
          seed <= prod[SEED_BITS-1:0];
          cnt  <= cnt - {32'd0, steps_r};
        end
        jlcg_pkg::OP_CHUNK: begin
          seed <= chunk_word[SEED_BITS-1:0];
          cnt  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      jlcg_pkg::OP_CAPTURE: begin
        kind_r    <= in_kind;
        seed_in_r <= in_seed;
        bits_r    <= in_bits;
        bound_r   <= in_bound;
        steps_r   <= in_steps;
        cx_r      <= {{32{in_cx[31]}}, in_cx};
        cz_r      <= {{32{in_cz[31]}}, in_cz};
      end
      jlcg_pkg::OP_LOAD_IN:  val  <= 64'(load_word[SEED_BITS-1:0]);
      jlcg_pkg::OP_STEP:     dr   <= dr_next;
      jlcg_pkg::OP_V_BITS:   val  <= {{32{dr[31]}}, dr};
      jlcg_pkg::OP_V_DRAW:   val  <= {32'd0, dr};
      jlcg_pkg::OP_V_HI:     hi_r <= dr;
      jlcg_pkg::OP_V_LONG:   val  <= {hi_r, 32'd0} + {{32{dr[31]}}, dr};
      jlcg_pkg::OP_V_DBL:    val  <= {11'd0, hi_r[25:0], dr[26:0]};
      jlcg_pkg::OP_V_PROD31: val  <= {31'd0, prod[63:31]};
      jlcg_pkg::OP_V_REM:    val  <= {33'd0, rem};
      jlcg_pkg::OP_PS_INITM: begin
        p_r  <= {16'd0, mult_r};
        s_r  <= 64'd1;
        ap_r <= 64'd1;
        as_r <= 64'd0;
        n_r  <= steps_r;
      end
      jlcg_pkg::OP_PS_INITI: begin
        p_r  <= {16'd0, inv_r};
        s_r  <= 64'd1;
        ap_r <= 64'd1;
        as_r <= 64'd0;
        n_r  <= steps_r;
      end
      jlcg_pkg::OP_PS_AS:  as_r <= as_r + prod;
      jlcg_pkg::OP_PS_AP:  ap_r <= prod;
      jlcg_pkg::OP_PS_S:   s_r  <= s_r + prod;
      jlcg_pkg::OP_PS_P: begin
        p_r <= prod;
        n_r <= {1'b0, n_r[31:1]};
      end
      jlcg_pkg::OP_SAVE_G: g_r  <= as_r;
      jlcg_pkg::OP_T:      t_r  <= prod;
      jlcg_pkg::OP_SUB:    t_r  <= seed64 - t_r;
      jlcg_pkg::OP_FWD:    val  <= 64'(fwd_sum[SEED_BITS-1:0]);
      jlcg_pkg::OP_BACK:   val  <= 64'(prod[SEED_BITS-1:0]);
      jlcg_pkg::OP_XS:     xs_r <= val;
      jlcg_pkg::OP_CHUNK:  val  <= chunk_v;
      jlcg_pkg::OP_ZERO:   val  <= '0;
      jlcg_pkg::OP_EMIT: begin
        out_value <= val;
        out_seed  <= seed64[47:0];
        out_count <= cnt;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/jlcg_ctrl.sv
// ----------------------------------------------------------------------------
// Generator controller
// Sequences each request through the datapath: seed loads, draws, the rejection
// loop, square-and-multiply jumps and chunk seed derivation.
// ----------------------------------------------------------------------------
module jlcg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  input  jlcg_pkg::stat_t st,
  output jlcg_pkg::cmd_t  cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_MUL_GO   = 5'd2;
  localparam logic [4:0] S_MUL_WAIT = 5'd3;
  localparam logic [4:0] S_K1       = 5'd4;
  localparam logic [4:0] S_K2P      = 5'd5;
  localparam logic [4:0] S_K2D      = 5'd6;
  localparam logic [4:0] S_K2W      = 5'd7;
  localparam logic [4:0] S_K2C      = 5'd8;
  localparam logic [4:0] S_K3A      = 5'd9;
  localparam logic [4:0] S_K3B      = 5'd10;
  localparam logic [4:0] S_K4       = 5'd11;
  localparam logic [4:0] S_K5A      = 5'd12;
  localparam logic [4:0] S_K5B      = 5'd13;
  localparam logic [4:0] S_PS_TEST  = 5'd14;
  localparam logic [4:0] S_PS_B     = 5'd15;
  localparam logic [4:0] S_PS_C     = 5'd16;
  localparam logic [4:0] S_PS_D     = 5'd17;
  localparam logic [4:0] S_PS_END   = 5'd18;
  localparam logic [4:0] S_PS_INIT2 = 5'd19;
  localparam logic [4:0] S_F2       = 5'd20;
  localparam logic [4:0] S_B2       = 5'd21;
  localparam logic [4:0] S_B3       = 5'd22;
  localparam logic [4:0] S_C1       = 5'd23;
  localparam logic [4:0] S_C2       = 5'd24;
  localparam logic [4:0] S_C3       = 5'd25;
  localparam logic [4:0] S_C4       = 5'd26;
  localparam logic [4:0] S_C5       = 5'd27;
  localparam logic [4:0] S_C6       = 5'd28;
  localparam logic [4:0] S_C7       = 5'd29;
  localparam logic [4:0] S_EMIT     = 5'd30;

  logic [4:0]          state;
  logic [4:0]          state_next;
  logic [4:0]          ret;
  logic [4:0]          ret_next;
  jlcg_pkg::msel_t     msel;
  jlcg_pkg::msel_t     msel_next;
  jlcg_pkg::op_t       wop;
  jlcg_pkg::op_t       wop_next;
  logic [5:0]          wid;
  logic [5:0]          wid_next;
  logic                pass2;
  logic                pass2_next;
  logic [9:0]          tries;
  logic [9:0]          tries_next;

  assign s_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    msel_next  = msel;
    wop_next   = wop;
    wid_next   = wid;
    pass2_next = pass2;
    tries_next = tries;
    cmd.op     = jlcg_pkg::OP_NONE;
    cmd.msel   = msel;
    cmd.width  = wid;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.op     = jlcg_pkg::OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        pass2_next = 1'b0;
        tries_next = '0;
        msel_next  = jlcg_pkg::M_SEED_MULT;
        wop_next   = jlcg_pkg::OP_STEP;
        wid_next   = jlcg_pkg::W_32;
        state_next = S_MUL_GO;
        unique case (st.kind)
          jlcg_pkg::KIND_LOAD: begin
            cmd.op     = jlcg_pkg::OP_LOAD_IN;
            state_next = S_EMIT;
          end
          jlcg_pkg::KIND_BITS: begin
            wid_next = st.bits;
            ret_next = S_K1;
          end
          jlcg_pkg::KIND_BOUND: begin
            wid_next = jlcg_pkg::W_31;
            ret_next = st.pow2 ? S_K2P : S_K2D;
          end
          jlcg_pkg::KIND_LONG:   ret_next = S_K3A;
          jlcg_pkg::KIND_FLOAT: begin
            wid_next = jlcg_pkg::W_24;
            ret_next = S_K4;
          end
          jlcg_pkg::KIND_DOUBLE: begin
            wid_next = jlcg_pkg::W_26;
            ret_next = S_K5A;
          end
          jlcg_pkg::KIND_FWD, jlcg_pkg::KIND_BACK: begin
            cmd.op     = jlcg_pkg::OP_PS_INITM;
            state_next = S_PS_TEST;
          end
          jlcg_pkg::KIND_CHUNK: begin
            cmd.op   = jlcg_pkg::OP_LOAD_IN;
            ret_next = S_C1;
          end
          default: begin
            cmd.op     = jlcg_pkg::OP_ZERO;
            state_next = S_EMIT;
          end
        endcase
      end
      S_MUL_GO: begin
        cmd.op     = jlcg_pkg::OP_MUL;
        state_next = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (st.mul_done) begin
          cmd.op     = wop;
          state_next = ret;
        end
      end
      S_K1: begin
        cmd.op     = jlcg_pkg::OP_V_BITS;
        state_next = S_EMIT;
      end
      S_K2P: begin
        msel_next  = jlcg_pkg::M_BOUND_DR;
        wop_next   = jlcg_pkg::OP_V_PROD31;
        ret_next   = S_EMIT;
        state_next = S_MUL_GO;
      end
      S_K2D: begin
        cmd.op     = jlcg_pkg::OP_DIV;
        state_next = S_K2W;
      end
      S_K2W: begin
        if (st.div_done) begin
          state_next = S_K2C;
        end
      end
      S_K2C: begin
        cmd.op = jlcg_pkg::OP_V_REM;
        if (!st.reject || tries == jlcg_pkg::RETRY_MAX) begin
          state_next = S_EMIT;
        end else begin
          tries_next = tries + 10'd1;
          ret_next   = S_K2D;
          state_next = S_MUL_GO;
        end
      end
      S_K3A: begin
        cmd.op     = jlcg_pkg::OP_V_HI;
        ret_next   = S_K3B;
        state_next = S_MUL_GO;
      end
      S_K3B: begin
        cmd.op     = jlcg_pkg::OP_V_LONG;
        state_next = S_EMIT;
      end
      S_K4: begin
        cmd.op     = jlcg_pkg::OP_V_DRAW;
        state_next = S_EMIT;
      end
      S_K5A: begin
        cmd.op     = jlcg_pkg::OP_V_HI;
        wid_next   = jlcg_pkg::W_27;
        ret_next   = S_K5B;
        state_next = S_MUL_GO;
      end
      S_K5B: begin
        cmd.op     = jlcg_pkg::OP_V_DBL;
        state_next = S_EMIT;
      end
      S_PS_TEST: begin
        if (st.n_zero) begin
          state_next = S_PS_END;
        end else if (st.n_lsb) begin
          msel_next  = jlcg_pkg::M_AP_S;
          wop_next   = jlcg_pkg::OP_PS_AS;
          ret_next   = S_PS_B;
          state_next = S_MUL_GO;
        end else begin
          state_next = S_PS_C;
        end
      end
      S_PS_B: begin
        msel_next  = jlcg_pkg::M_AP_P;
        wop_next   = jlcg_pkg::OP_PS_AP;
        ret_next   = S_PS_C;
        state_next = S_MUL_GO;
      end
      S_PS_C: begin
        msel_next  = jlcg_pkg::M_P_S;
        wop_next   = jlcg_pkg::OP_PS_S;
        ret_next   = S_PS_D;
        state_next = S_MUL_GO;
      end
      S_PS_D: begin
        msel_next  = jlcg_pkg::M_P_P;
        wop_next   = jlcg_pkg::OP_PS_P;
        ret_next   = S_PS_TEST;
        state_next = S_MUL_GO;
      end
      S_PS_END: begin
        if (pass2) begin
          msel_next  = jlcg_pkg::M_INC_G;
          wop_next   = jlcg_pkg::OP_T;
          ret_next   = S_B2;
          state_next = S_MUL_GO;
        end else begin
          cmd.op = jlcg_pkg::OP_SAVE_G;
          if (st.kind == jlcg_pkg::KIND_FWD) begin
            msel_next  = jlcg_pkg::M_AP_SEED;
            wop_next   = jlcg_pkg::OP_T;
            ret_next   = S_F2;
            state_next = S_MUL_GO;
          end else begin
            state_next = S_PS_INIT2;
          end
        end
      end
      S_PS_INIT2: begin
        cmd.op     = jlcg_pkg::OP_PS_INITI;
        pass2_next = 1'b1;
        state_next = S_PS_TEST;
      end
      S_F2: begin
        msel_next  = jlcg_pkg::M_INC_G;
        wop_next   = jlcg_pkg::OP_FWD;
        ret_next   = S_EMIT;
        state_next = S_MUL_GO;
      end
      S_B2: begin
        cmd.op     = jlcg_pkg::OP_SUB;
        state_next = S_B3;
      end
      S_B3: begin
        msel_next  = jlcg_pkg::M_T_AP;
        wop_next   = jlcg_pkg::OP_BACK;
        ret_next   = S_EMIT;
        state_next = S_MUL_GO;
      end
      S_C1: begin
        cmd.op     = jlcg_pkg::OP_V_HI;
        ret_next   = S_C2;
        state_next = S_MUL_GO;
      end
      S_C2: begin
        cmd.op     = jlcg_pkg::OP_V_LONG;
        state_next = S_C3;
      end
      S_C3: begin
        cmd.op     = jlcg_pkg::OP_XS;
        ret_next   = S_C4;
        state_next = S_MUL_GO;
      end
      S_C4: begin
        cmd.op     = jlcg_pkg::OP_V_HI;
        ret_next   = S_C5;
        state_next = S_MUL_GO;
      end
      S_C5: begin
        cmd.op     = jlcg_pkg::OP_V_LONG;
        state_next = S_C6;
      end
      S_C6: begin
        msel_next  = jlcg_pkg::M_CX_XS;
        wop_next   = jlcg_pkg::OP_T;
        ret_next   = S_C7;
        state_next = S_MUL_GO;
      end
      S_C7: begin
        msel_next  = jlcg_pkg::M_CZ_ZS;
        wop_next   = jlcg_pkg::OP_CHUNK;
        ret_next   = S_EMIT;
        state_next = S_MUL_GO;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.op     = jlcg_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      msel  <= jlcg_pkg::M_SEED_MULT;
      wop   <= jlcg_pkg::OP_NONE;
      wid   <= jlcg_pkg::W_32;
      pass2 <= 1'b0;
      tries <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      msel  <= msel_next;
      wop   <= wop_next;
      wid   <= wid_next;
      pass2 <= pass2_next;
      tries <= tries_next;
    end
  end

`ifndef SYNTHESIS
  a_wait_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_WAIT && !st.mul_done) |=> (state == S_MUL_WAIT))
    else $error("controller left the multiply wait early");
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready) |=> (state == S_DISPATCH))
    else $error("accepted item not dispatched");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == jlcg_pkg::OP_EMIT) |-> st.out_free)
    else $error("result written over a pending result");
`endif

endmodule
